### sv/msd_pkg.sv
// Shared types and constants of the moving sum decimator.
// Used by the stream interfaces, the decimation unit and the top level.
// No dependencies.
package msd_pkg;

    localparam int WIN_CFG_BITS   = 9;
    localparam int INTERVAL_BITS  = 16;
    localparam int PHASE_BITS     = INTERVAL_BITS;
    localparam int PHASE_STEP     = 256;
    localparam int SUM_OUT_BITS   = 24;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [WIN_CFG_BITS-1:0]  WINDOW_RESET   = 9'd64;
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 16'd256;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_LENGTH       = 1'b0,
        REG_DECIMATION_INTERVAL = 1'b1
    } cfg_reg_t;

    typedef logic signed [SUM_OUT_BITS-1:0] window_sum_t;

endpackage

### sv/msd_stream_if.sv
// Valid/ready stream interfaces of the moving sum decimator.
// msd_sample_if carries input samples, msd_sum_if carries window sums.
// Depends on msd_pkg.
interface msd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface msd_sum_if;
    import msd_pkg::*;

    logic        valid;
    logic        ready;
    window_sum_t window_sum;

    modport source (output valid, output window_sum, input ready);
    modport sink   (input valid, input window_sum, output ready);
endinterface

### sv/msd_cell.sv
// One stage of the sample row: holds one stored sample of the window.
// It shifts toward the head on removal and loads the new sample at its slot.
// No package dependencies.
module msd_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_BITS    = 8,
    parameter int INDEX       = 0
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic                          shift,
    input  logic                          ins_en,
    input  logic [IDX_BITS-1:0]           ins_idx,
    input  logic signed [SAMPLE_BITS-1:0] new_sample,
    input  logic signed [SAMPLE_BITS-1:0] neighbor,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    logic signed [SAMPLE_BITS-1:0] sample_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (ins_en && (ins_idx == IDX_BITS'(INDEX)))
            begin
                sample_reg <= new_sample;
            end
            else if (shift)
            begin
                sample_reg <= neighbor;
            end
        end
    end

    assign sample = sample_reg;

endmodule

### sv/msd_decim.sv
// Fractional decimation unit: tracks the distance to the next emission
// in 1/256 sample units and flags the samples whose sum is emitted.
// Depends on msd_pkg.
module msd_decim (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic [msd_pkg::INTERVAL_BITS-1:0]  interval,
    output logic                               emit
);
    import msd_pkg::*;

    logic        [PHASE_BITS-1:0] phase_reg;
    logic        [PHASE_BITS-1:0] phase_next;
    logic signed [PHASE_BITS+1:0] reload_sum;

    // The phase stays within 0 .. 65535, so one step always emits when it
    // is at most one sample away.
    assign emit = (phase_reg <= PHASE_BITS'(PHASE_STEP));

    assign reload_sum = $signed({2'b00, phase_reg}) + $signed({2'b00, interval})
                        - $signed((PHASE_BITS + 2)'(PHASE_STEP));

    always_comb
    begin
        if (emit)
        begin
            if (reload_sum < 0)
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = reload_sum[PHASE_BITS-1:0];
            end
        end
        else
        begin
            phase_next = phase_reg - PHASE_BITS'(PHASE_STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
        end
    end

    a_first_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (phase_reg == '0)) |-> emit)
        else $error("decimator skipped an emission at zero phase");

    a_phase_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !emit) |=> (phase_reg < $past(phase_reg)))
        else $error("decimator phase did not drop without emission");

endmodule

### sv/moving_sum_decimator.sv
// Boxcar moving sum with fractional decimation. One sample is taken per clock
// cycle unless an untaken sum stalls the input; the window sum of an emitted
// sample appears on sum_ch in the cycle after its beat, held until taken, while
// further samples keep flowing as long as the output register is free or being
// drained. Samples of the window live in a row of WINDOW_MAX cells that shift
// toward the head as the oldest sample leaves the sum, so one add, one subtract
// and one phase update per beat set the rate. Emitted sums saturate to 24 bits.
// Depends on msd_pkg, msd_stream_if, msd_cell and msd_decim.
module moving_sum_decimator #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [msd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [msd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    msd_sample_if.sink                          sample_ch,
    msd_sum_if.source                           sum_ch
);
    import msd_pkg::*;

    localparam int FILL_BITS = $clog2(WINDOW_MAX);
    localparam int WIN_BITS  = ($clog2(WINDOW_MAX + 1) > WIN_CFG_BITS) ?
                               $clog2(WINDOW_MAX + 1) : WIN_CFG_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int CMP_BITS  = (SUM_BITS > SUM_OUT_BITS) ? SUM_BITS : SUM_OUT_BITS;

    localparam logic signed [CMP_BITS-1:0] SAT_MAX = CMP_BITS'((2 ** (SUM_OUT_BITS - 1)) - 1);
    localparam logic signed [CMP_BITS-1:0] SAT_MIN = CMP_BITS'(-(2 ** (SUM_OUT_BITS - 1)));

    logic [WIN_CFG_BITS-1:0]  window_length_reg;
    logic [INTERVAL_BITS-1:0] interval_reg;

    logic [FILL_BITS-1:0]       fill_reg;
    logic [FILL_BITS-1:0]       fill_next;
    logic signed [SUM_BITS-1:0] running_sum_reg;
    logic signed [SUM_BITS-1:0] running_sum_next;
    logic                       sum_valid_reg;
    window_sum_t                window_sum_reg;

    logic                          accept;
    logic                          emit;
    logic                          pop;
    logic                          ins_en;
    logic [FILL_BITS-1:0]          ins_idx;
    logic [WIN_BITS-1:0]           win_ext;
    logic [WIN_BITS-1:0]           win_eff;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] head;
    logic signed [SUM_BITS-1:0]    sum_in;
    logic signed [CMP_BITS-1:0]    sum_wide;
    window_sum_t                   sum_sat;
    logic signed [SAMPLE_BITS-1:0] cell_data [WINDOW_MAX];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
            interval_reg      <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_LENGTH:       window_length_reg <= cfg_data[WIN_CFG_BITS-1:0];
                REG_DECIMATION_INTERVAL: interval_reg      <= cfg_data[INTERVAL_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    assign win_ext = WIN_BITS'(window_length_reg);

    always_comb
    begin
        if (win_ext == '0)
        begin
            win_eff = WIN_BITS'(1);
        end
        else if (win_ext > WIN_BITS'(WINDOW_MAX))
        begin
            win_eff = WIN_BITS'(WINDOW_MAX);
        end
        else
        begin
            win_eff = win_ext;
        end
    end

    assign x               = sample_ch.sample_in;
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = !sum_valid_reg || sum_ch.ready;

    // The oldest sample leaves once the count including this beat reaches the
    // window. With a window of one and nothing stored, it is the new sample.
    assign pop     = (WIN_BITS'(fill_reg) >= (win_eff - WIN_BITS'(1)));
    assign ins_en  = !(pop && (fill_reg == '0));
    assign ins_idx = fill_reg - FILL_BITS'(pop);
    assign head    = (fill_reg == '0) ? x : cell_data[0];

    genvar k;
    generate
        for (k = 0; k < WINDOW_MAX; k++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] neighbor;

            if (k < WINDOW_MAX - 1)
            begin : g_inner
                assign neighbor = cell_data[k + 1];
            end
            else
            begin : g_last
                assign neighbor = x;
            end

            msd_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .IDX_BITS    (FILL_BITS),
                .INDEX       (k)
            ) u_cell (
                .clk        (clk),
                .load       (accept),
                .shift      (pop),
                .ins_en     (ins_en),
                .ins_idx    (ins_idx),
                .new_sample (x),
                .neighbor   (neighbor),
                .sample     (cell_data[k])
            );
        end
    endgenerate

    msd_decim u_decim (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (accept),
        .interval (interval_reg),
        .emit     (emit)
    );

    assign sum_in   = running_sum_reg + SUM_BITS'(x);
    assign sum_wide = CMP_BITS'(sum_in);

    always_comb
    begin
        if (sum_wide > SAT_MAX)
        begin
            sum_sat = $signed(SAT_MAX[SUM_OUT_BITS-1:0]);
        end
        else if (sum_wide < SAT_MIN)
        begin
            sum_sat = $signed(SAT_MIN[SUM_OUT_BITS-1:0]);
        end
        else
        begin
            sum_sat = $signed(sum_wide[SUM_OUT_BITS-1:0]);
        end
    end

    assign running_sum_next = pop ? (sum_in - SUM_BITS'(head)) : sum_in;
    assign fill_next        = pop ? fill_reg : (fill_reg + FILL_BITS'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            running_sum_reg <= '0;
            sum_valid_reg   <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg        <= fill_next;
            running_sum_reg <= running_sum_next;
            sum_valid_reg   <= emit;
        end
        else if (sum_ch.ready)
        begin
            sum_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            window_sum_reg <= sum_sat;
        end
    end

    assign sum_ch.valid      = sum_valid_reg;
    assign sum_ch.window_sum = window_sum_reg;

    a_emit_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (sum_valid_reg == $past(emit)))
        else $error("output beat does not match the emission decision");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (WIN_BITS'(fill_reg) <= WIN_BITS'(WINDOW_MAX - 1)))
        else $error("sample row overfilled");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pop && (fill_reg == '0)) |-> (win_eff == WIN_BITS'(1)))
        else $error("removal from an empty row with a window above one");

endmodule
